// ===== rtl/core/swm_pkg.sv =====
package swm_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int CFG_BITS        = 7;

  localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = 7'd1;

  // Where a cell's content goes in the next sorted order.
  typedef struct packed {
    logic up;
    logic stay;
    logic down;
  } swm_move_t;

endpackage

// ===== rtl/core/swm_if.sv =====
interface swm_in_if #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swm_out_if #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

// ===== rtl/core/swm_cell.sv =====
module swm_cell #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
  parameter int AW          = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift_en,
  input  logic                          clear,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] old_val,
  input  logic                          full,
  input  logic [AW-1:0]                 last_age,
  input  swm_pkg::swm_move_t            left_move,
  input  logic signed [SAMPLE_BITS-1:0] left_val,
  input  logic [AW-1:0]                 left_age,
  input  logic                          left_valid,
  input  swm_pkg::swm_move_t            right_move,
  input  logic signed [SAMPLE_BITS-1:0] right_val,
  input  logic [AW-1:0]                 right_age,
  input  logic                          right_valid,
  output swm_pkg::swm_move_t            own_move,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic [AW-1:0]                 age,
  output logic                          valid,
  output logic                          del
);
  import swm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] val_r, val_nxt;
  logic [AW-1:0]                 age_r, age_nxt;
  logic                          valid_r, valid_nxt;
  logic                          above_del;
  logic                          below_new;

  // Cells are kept in ascending order; among equal values the younger sits lower.
  assign del       = valid_r && full && (age_r == last_age);
  assign above_del = full && (val_r > old_val);
  assign below_new = val_r < sample;

  always_comb begin
    own_move = '0;
    if (!valid_r) begin
      own_move.up   = !full;
      own_move.stay = full;
    end else if (!del) begin
      own_move.up   = !below_new && !above_del;
      own_move.down = below_new && above_del;
      own_move.stay = below_new == above_del ? 1'b0 : 1'b1;
    end
  end

  always_comb begin
    if (left_move.up) begin
      val_nxt   = left_val;
      age_nxt   = left_age + AW'(1);
      valid_nxt = left_valid;
    end else if (own_move.stay) begin
      val_nxt   = val_r;
      age_nxt   = age_r + AW'(1);
      valid_nxt = valid_r;
    end else if (right_move.down) begin
      val_nxt   = right_val;
      age_nxt   = right_age + AW'(1);
      valid_nxt = right_valid;
    end else begin
      val_nxt   = sample;
      age_nxt   = '0;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clear) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign val   = val_r;
  assign age   = age_r;
  assign valid = valid_r;

endmodule

// ===== rtl/core/sliding_window_median.sv =====
// Running median filter over the most recent window_size samples.
// Samples arrive on in_ch; each accepted item enters a row of cells that
// keeps the window in ascending order, the oldest sample leaving as the new
// one is inserted, all in the cycle of acceptance.
// Once the window holds window_size samples, every item yields one result on
// out_ch: the element of rank ceil(window_size/2), the lower median for even
// sizes. While the window fills, items give no result.
// An accepted item is sorted in the cell row, then its result is registered.
// One item is taken per cycle as long as the receiver takes results; the
// throughput is set by the single output register, which a pending result
// must reach first. When the receiver stalls, one result waits in the
// output register and one more in the cell row; further items are refused
// until the backlog clears. A window size of zero acts as one, and sizes
// above MAX_WINDOW saturate. Reset, and every write to cfg_wr_data, empties
// the window; reset sets the window size to one. Configuration must be
// written only while the block is idle; the block does not enforce this.
module sliding_window_median #(
  parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  swm_in_if.sink                        in_ch,
  swm_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [swm_pkg::CFG_BITS-1:0]  cfg_wr_data
);
  import swm_pkg::*;

  localparam int KW = $clog2(MAX_WINDOW + 1);
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = (KW > CFG_BITS) ? KW : CFG_BITS;

  logic [CFG_BITS-1:0]           window_size_r;
  logic [KW-1:0]                 fill_r, fill_nxt;
  logic                          emit_r, emit_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] median_r;

  logic [KW-1:0]                 k_eff;
  logic [KW-1:0]                 k_less1;
  logic [AW-1:0]                 last_age;
  logic [AW-1:0]                 rank_idx;
  logic                          full;
  logic                          accept;
  logic                          slot_free;
  logic                          load_out;
  logic                          gives_result;
  logic signed [SAMPLE_BITS-1:0] old_val;

  swm_move_t                     move    [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] vals    [MAX_WINDOW];
  logic [AW-1:0]                 ages    [MAX_WINDOW];
  logic                          valids  [MAX_WINDOW];
  logic                          dels    [MAX_WINDOW];
  swm_move_t                     l_move  [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] l_val   [MAX_WINDOW];
  logic [AW-1:0]                 l_age   [MAX_WINDOW];
  logic                          l_valid [MAX_WINDOW];
  swm_move_t                     r_move  [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] r_val   [MAX_WINDOW];
  logic [AW-1:0]                 r_age   [MAX_WINDOW];
  logic                          r_valid [MAX_WINDOW];

  always_comb begin
    if (window_size_r == '0) begin
      k_eff = KW'(1);
    end else if (CW'(window_size_r) > CW'(MAX_WINDOW)) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(window_size_r);
    end
  end

  assign k_less1  = k_eff - KW'(1);
  assign last_age = AW'(k_less1);
  assign rank_idx = AW'(k_less1 >> 1);
  assign full     = fill_r == k_eff;

  always_comb begin
    old_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      old_val = old_val | (dels[i] ? vals[i] : '0);
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_left_end
      assign l_move[i]  = '0;
      assign l_val[i]   = '0;
      assign l_age[i]   = '0;
      assign l_valid[i] = 1'b0;
    end else begin : g_left
      assign l_move[i]  = move[i-1];
      assign l_val[i]   = vals[i-1];
      assign l_age[i]   = ages[i-1];
      assign l_valid[i] = valids[i-1];
    end
    if (i == MAX_WINDOW - 1) begin : g_right_end
      assign r_move[i]  = '0;
      assign r_val[i]   = '0;
      assign r_age[i]   = '0;
      assign r_valid[i] = 1'b0;
    end else begin : g_right
      assign r_move[i]  = move[i+1];
      assign r_val[i]   = vals[i+1];
      assign r_age[i]   = ages[i+1];
      assign r_valid[i] = valids[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AW          (AW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .shift_en    (accept),
      .clear       (cfg_wr_en),
      .sample      (in_ch.sample),
      .old_val     (old_val),
      .full        (full),
      .last_age    (last_age),
      .left_move   (l_move[i]),
      .left_val    (l_val[i]),
      .left_age    (l_age[i]),
      .left_valid  (l_valid[i]),
      .right_move  (r_move[i]),
      .right_val   (r_val[i]),
      .right_age   (r_age[i]),
      .right_valid (r_valid[i]),
      .own_move    (move[i]),
      .val         (vals[i]),
      .age         (ages[i]),
      .valid       (valids[i]),
      .del         (dels[i])
    );
  end

  assign slot_free    = !out_valid_r || out_ch.ready;
  assign load_out     = emit_r && slot_free;
  assign in_ch.ready  = !emit_r || slot_free;
  assign accept       = in_ch.valid && in_ch.ready;
  assign gives_result = full || ((fill_r + KW'(1)) == k_eff);

  always_comb begin
    fill_nxt = fill_r;
    if (cfg_wr_en) begin
      fill_nxt = '0;
    end else if (accept && !full) begin
      fill_nxt = fill_r + KW'(1);
    end

    emit_nxt = emit_r;
    if (accept) begin
      emit_nxt = gives_result;
    end else if (load_out) begin
      emit_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_SIZE_RESET;
      fill_r        <= '0;
      emit_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_size_r <= cfg_wr_data;
      end
      fill_r      <= fill_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      median_r <= vals[rank_idx];
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.median = median_r;

endmodule

// ===== tb/sv/tb_sliding_window_median.sv =====
module tb_sliding_window_median;
  timeunit 1ns;
  timeprecision 1ps;

  import swm_pkg::*;

  localparam int MAXW        = MAX_WINDOW_DEF;
  localparam int SBITS       = SAMPLE_BITS_DEF;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 4;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_BITS-1:0]    size;
    logic signed [SBITS-1:0] sample;
    bit                     pinned;
    logic signed [SBITS-1:0] median;
  } stim_row_t;

  typedef struct packed {
    bit                      pinned;
    logic signed [SBITS-1:0] median;
  } pin_t;

  localparam int DIR_ROWS = 26;
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_SAMPLE, 7'd0,   32'sh7fff_ffff, 1'b1, 32'sh7fff_ffff},
    '{ROW_SAMPLE, 7'd0,   32'sh8000_0000, 1'b1, 32'sh8000_0000},
    '{ROW_SAMPLE, 7'd0,   32'sh0000_0000, 1'b1, 32'sh0000_0000},
    '{ROW_SAMPLE, 7'd0,   32'shffff_ffff, 1'b1, 32'shffff_ffff},
    '{ROW_SAMPLE, 7'd0,   32'sh5555_5555, 1'b1, 32'sh5555_5555},
    '{ROW_SAMPLE, 7'd0,   32'shaaaa_aaaa, 1'b1, 32'shaaaa_aaaa},
    '{ROW_CFG,    7'd0,   32'sh0000_0000, 1'b0, 32'sh0000_0000},
    '{ROW_SAMPLE, 7'd0,   32'sh0000_007b, 1'b1, 32'sh0000_007b},
    '{ROW_SAMPLE, 7'd0,   32'shffff_fffe, 1'b1, 32'shffff_fffe},
    '{ROW_CFG,    7'd3,   32'sh0000_0000, 1'b0, 32'sh0000_0000},
    '{ROW_SAMPLE, 7'd0,   32'sh0000_000a, 1'b0, 32'sh0000_0000},
    '{ROW_SAMPLE, 7'd0,   32'shffff_fff6, 1'b0, 32'sh0000_0000},
    '{ROW_SAMPLE, 7'd0,   32'sh0000_000a, 1'b0, 32'sh0000_0000},
    '{ROW_SAMPLE, 7'd0,   32'shffff_fff6, 1'b0, 32'sh0000_0000},
    '{ROW_SAMPLE, 7'd0,   32'sh0000_0007, 1'b0, 32'sh0000_0000},
    '{ROW_SAMPLE, 7'd0,   32'sh0000_0007, 1'b0, 32'sh0000_0000},
    '{ROW_SAMPLE, 7'd0,   32'sh0000_0007, 1'b0, 32'sh0000_0000},
    '{ROW_CFG,    7'd2,   32'sh0000_0000, 1'b0, 32'sh0000_0000},
    '{ROW_SAMPLE, 7'd0,   32'sh7fff_ffff, 1'b0, 32'sh0000_0000},
    '{ROW_SAMPLE, 7'd0,   32'sh8000_0000, 1'b0, 32'sh0000_0000},
    '{ROW_SAMPLE, 7'd0,   32'sh8000_0000, 1'b0, 32'sh0000_0000},
    '{ROW_CFG,    7'd127, 32'sh0000_0000, 1'b0, 32'sh0000_0000},
    '{ROW_SAMPLE, 7'd0,   32'sh0000_0001, 1'b0, 32'sh0000_0000},
    '{ROW_SAMPLE, 7'd0,   32'sh0000_0002, 1'b0, 32'sh0000_0000},
    '{ROW_CFG,    7'd1,   32'sh0000_0000, 1'b0, 32'sh0000_0000},
    '{ROW_SAMPLE, 7'd0,   32'sh8000_0001, 1'b1, 32'sh8000_0001}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CFG_BITS-1:0] cfg_wr_data;

  swm_in_if  #(.SAMPLE_BITS(SBITS)) in_ch ();
  swm_out_if #(.SAMPLE_BITS(SBITS)) out_ch ();

  sliding_window_median dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  logic signed [SBITS-1:0] win_mem [MAXW];
  int unsigned             win_fill;
  int unsigned             win_oldest;
  logic [CFG_BITS-1:0]     win_size;

  logic signed [SBITS-1:0] median_q [$];
  pin_t                    pin_q [$];
  int                      errors;
  int                      stall_cycles;
  bit                      in_idle_en;
  bit                      out_idle_en;
  bit                      hold_req;

  function automatic int unsigned eff_size(input logic [CFG_BITS-1:0] v);
    int unsigned k;
    k = 32'(v);
    if (k == 0) k = 1;
    if (k > MAXW) k = MAXW;
    return k;
  endfunction

  function automatic logic signed [SBITS-1:0] window_rank_median(input int unsigned k);
    logic signed [SBITS-1:0] srt [MAXW];
    logic signed [SBITS-1:0] v;
    int i;
    int j;
    for (i = 0; i < k; i++) srt[i] = win_mem[i];
    for (i = 1; i < k; i++) begin
      v = srt[i];
      j = i - 1;
      while (j >= 0 && srt[j] > v) begin
        srt[j+1] = srt[j];
        j--;
      end
      srt[j+1] = v;
    end
    return srt[(k + 1) / 2 - 1];
  endfunction

  task automatic window_take(input logic signed [SBITS-1:0] s, output bit got,
                             output logic signed [SBITS-1:0] med);
    int unsigned k;
    k = eff_size(win_size);
    if (win_fill < k) begin
      win_mem[win_fill] = s;
      win_fill++;
    end else begin
      win_mem[win_oldest] = s;
      win_oldest++;
      if (win_oldest >= k) win_oldest = 0;
    end
    got = (win_fill >= k);
    med = got ? window_rank_median(k) : '0;
  endtask

  function automatic logic signed [SBITS-1:0] rand_sample();
    logic signed [SBITS-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3, 4, 5: v = $signed($urandom_range(0, 16)) - 8;
      6: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh7fff_ffff;
          1:       v = 32'sh8000_0000;
          2:       v = 32'sh0000_0000;
          default: v = 32'shffff_ffff;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    bit                      got;
    logic signed [SBITS-1:0] med;
    pin_t                    pin;
    bit                      moved;
    moved = 1'b0;
    if (!rst_n) begin
      win_fill   = 0;
      win_oldest = 0;
      win_size   = WINDOW_SIZE_RESET;
    end else begin
      if (cfg_wr_en) begin
        win_size   = cfg_wr_data;
        win_fill   = 0;
        win_oldest = 0;
        moved      = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        pin = pin_q.pop_front();
        window_take(in_ch.sample, got, med);
        if (got) median_q.push_back(pin.pinned ? pin.median : med);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (median_q.size() == 0) begin
          $error("median: no item expected, got %0d", out_ch.median);
          errors++;
        end else begin
          med = median_q.pop_front();
          if (out_ch.median !== med) begin
            $error("median: expected %0d, got %0d", med, out_ch.median);
            errors++;
          end
        end
      end
    end
    stall_cycles <= moved ? 0 : stall_cycles + 1;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= !(out_idle_en && $urandom_range(0, 99) < 10);
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_sample(input logic signed [SBITS-1:0] s, input bit pinned,
                             input logic signed [SBITS-1:0] med);
    @(negedge clk);
    while (in_idle_en && $urandom_range(0, 99) < 10) begin
      in_ch.valid  <= 1'b0;
      in_ch.sample <= $urandom;
      @(negedge clk);
    end
    pin_q.push_back('{pinned, med});
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_window(input logic [CFG_BITS-1:0] v);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (median_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int                  phase_sizes [14];
    logic [CFG_BITS-1:0] sz;
    int                  n;
    phase_sizes  = '{1, 2, 3, 4, 5, 8, 16, 31, 64, 127, 0, 100, 40, 0};
    errors       = 0;
    stall_cycles = 0;
    hold_req     = 1'b0;
    in_idle_en   = 1'b1;
    out_idle_en  = 1'b1;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TAB[r].kind == ROW_CFG) begin
        write_window(DIR_TAB[r].size);
      end else begin
        send_sample(DIR_TAB[r].sample, DIR_TAB[r].pinned, DIR_TAB[r].median);
      end
    end

    // The window of five also carries the long receiver hold-off, so that the
    // block backs up and refuses items while the sender keeps offering them.
    for (int p = 0; p < 14; p++) begin
      sz = (p == 13) ? CFG_BITS'($urandom_range(1, MAXW)) : CFG_BITS'(phase_sizes[p]);
      write_window(sz);
      if (sz == 5) hold_req = 1'b1;
      in_idle_en  = (sz != 64);
      out_idle_en = (sz != 64);
      n = eff_size(sz) + 60 + $urandom_range(0, 20);
      repeat (n) send_sample(rand_sample(), 1'b0, '0);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (median_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (median_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/swm_pkg.sv
rtl/core/swm_if.sv
rtl/core/swm_cell.sv
rtl/core/sliding_window_median.sv
tb/sv/tb_sliding_window_median.sv
